FILE: hdl/sstt_pkg.sv
// ----------------------------------------------------------------------------
// sstt_pkg
// Types and constants shared by the sorted session time table.
// ----------------------------------------------------------------------------
package sstt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 31;
    localparam int TIME_W    = 64;
    localparam int LIVE_W    = 7;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        op_t               operation;
        logic [KEY_W-1:0]  session_key;
        logic [TIME_W-1:0] time_value;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [TIME_W-1:0] found_time;
        logic [LIVE_W-1:0] live_count;
    } out_t;

    // One table slot as stored in the entry RAM.
    typedef struct packed {
        logic              live;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] tv;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP_RD,
        S_CMP_EV,
        S_INS_RD,
        S_INS_EV,
        S_POP_HD,
        S_SKIP_RD,
        S_SKIP_EV,
        S_SRCH_RD,
        S_SRCH_EV,
        S_DONE
    } seq_state_t;

endpackage

FILE: hdl/sstt_ram.sv
// ----------------------------------------------------------------------------
// sstt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/sstt_seq.sv
// ----------------------------------------------------------------------------
// sstt_seq
// Sequencer and datapath: walks the entry RAM one slot per step for
// compaction, insertion, head skipping and binary search.
// ----------------------------------------------------------------------------
module sstt_seq #(
    parameter int DEPTH = sstt_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  sstt_pkg::in_t req_data,
    input  logic          out_free,
    output logic          res_valid,
    output sstt_pkg::out_t res_data
);
    import sstt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    seq_state_t        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     span_reg, span_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     wptr_reg, wptr_next;
    logic [CW-1:0]     mid_reg, mid_next;
    in_t               req_reg, req_next;
    status_t           status_reg, status_next;
    logic [TIME_W-1:0] found_reg, found_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ent_t              wr_ent;
    logic [AW-1:0]     rd_addr;
    logic [ENT_W-1:0]  rd_raw;
    ent_t              rd_ent;
    logic [CW:0]       mid_sum;
    ent_t              new_ent;

    // Slot at a given offset from the head, wrapped once.
    function automatic logic [AW-1:0] ring(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(off);
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    sstt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_ent    = ent_t'(rd_raw);
    assign req_ready = (state_reg == S_IDLE);
    assign mid_sum   = (CW + 1)'(ptr_reg) + (CW + 1)'(wptr_reg);
    assign new_ent   = '{live: 1'b1, key: req_reg.session_key, tv: req_reg.time_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            span_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            span_reg  <= span_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        wptr_reg   <= wptr_next;
        mid_reg    <= mid_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        span_next   = span_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        wptr_next   = wptr_reg;
        mid_next    = mid_reg;
        req_next    = req_reg;
        status_next = status_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        wr_addr     = ring(head_reg, ptr_reg);
        wr_ent      = new_ent;
        rd_addr     = ring(head_reg, ptr_reg);
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = head_reg;
                if (req_valid) begin
                    req_next    = req_data;
                    found_next  = '0;
                    status_next = ST_DONE;
                    if (req_data.operation == OP_PUSH) begin
                        if (cnt_reg >= DEPTH_C) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (span_reg == '0) begin
                            head_next  = '0;
                            ptr_next   = '0;
                            state_next = S_INS_RD;
                        end else if (span_reg >= DEPTH_C) begin
                            ptr_next   = '0;
                            wptr_next  = '0;
                            state_next = S_CMP_RD;
                        end else begin
                            ptr_next   = span_reg;
                            state_next = S_INS_RD;
                        end
                    end else begin
                        if (span_reg == '0) begin
                            status_next = ST_MISS;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_POP_HD;
                        end
                    end
                end
            end
            S_CMP_RD: begin
                if (ptr_reg < span_reg) begin
                    state_next = S_CMP_EV;
                end else begin
                    // Live entries packed; the span shrinks to the live count.
                    span_next  = wptr_reg;
                    ptr_next   = wptr_reg;
                    state_next = S_INS_RD;
                end
            end
            S_CMP_EV: begin
                if (rd_ent.live) begin
                    wr_en     = 1'b1;
                    wr_addr   = ring(head_reg, wptr_reg);
                    wr_ent    = rd_ent;
                    wptr_next = wptr_reg + 1'b1;
                end
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_CMP_RD;
            end
            S_INS_RD: begin
                rd_addr = ring(head_reg, ptr_reg - 1'b1);
                if (ptr_reg == '0) begin
                    wr_en      = 1'b1;
                    span_next  = span_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV: begin
                wr_en = 1'b1;
                if (req_reg.session_key > rd_ent.key) begin
                    span_next  = span_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    // Shift the older entry one slot toward the tail.
                    wr_ent     = rd_ent;
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = S_INS_RD;
                end
            end
            S_POP_HD: begin
                if (rd_ent.live && rd_ent.key == req_reg.session_key) begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_ent     = '{live: 1'b0, key: rd_ent.key, tv: rd_ent.tv};
                    found_next = rd_ent.tv;
                    cnt_next   = cnt_reg - 1'b1;
                    head_next  = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
                    span_next  = span_reg - 1'b1;
                    state_next = S_SKIP_RD;
                end else begin
                    ptr_next   = CW'(1);
                    wptr_next  = span_reg;
                    state_next = S_SRCH_RD;
                end
            end
            S_SKIP_RD: begin
                rd_addr = head_reg;
                if (span_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SKIP_EV;
                end
            end
            S_SKIP_EV: begin
                if (rd_ent.live) begin
                    state_next = S_DONE;
                end else begin
                    head_next  = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
                    span_next  = span_reg - 1'b1;
                    state_next = S_SKIP_RD;
                end
            end
            S_SRCH_RD: begin
                rd_addr = ring(head_reg, mid_sum[CW:1]);
                if (ptr_reg < wptr_reg) begin
                    mid_next   = mid_sum[CW:1];
                    state_next = S_SRCH_EV;
                end else begin
                    status_next = ST_MISS;
                    state_next  = S_DONE;
                end
            end
            S_SRCH_EV: begin
                if (rd_ent.key == req_reg.session_key) begin
                    if (!rd_ent.live) begin
                        status_next = ST_MISS;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = ring(head_reg, mid_reg);
                        wr_ent     = '{live: 1'b0, key: rd_ent.key, tv: rd_ent.tv};
                        cnt_next   = cnt_reg - 1'b1;
                        found_next = rd_ent.tv;
                    end
                    state_next = S_DONE;
                end else begin
                    if (req_reg.session_key > rd_ent.key) begin
                        ptr_next = mid_reg + 1'b1;
                    end else begin
                        wptr_next = mid_reg;
                    end
                    state_next = S_SRCH_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_data = '{status: status_reg, found_time: found_reg,
                        live_count: LIVE_W'(cnt_reg)};

endmodule

FILE: hdl/sorted_session_time_table.sv
// ----------------------------------------------------------------------------
// sorted_session_time_table
// Key-sorted ring table of session entries with push and pop by key.
// ----------------------------------------------------------------------------
// Every input beat produces exactly one result beat. Operations run one at a
// time against a single entry RAM (one write and one registered read per
// cycle), so the cost is set by how many slots the sequencer must visit.
// Work done per operation:
// - A push into an empty table writes its entry directly.
// - Any other push walks back from the tail, moving each entry it passes
//   one slot toward the tail.
// - When the ring is in full use with removed slots, a compaction sweep
//   first packs the live entries.
// - A pop of the head clears it, then skips the removed slots behind it.
// - Any other pop runs a binary search (about log2 DEPTH probes).
// - A full-table push or a pop on an empty table does no RAM work.
// m_valid rises when the result register is loaded. s_ready is high only
// while the sequencer is idle, which is the cycle after the result is
// loaded; a finished result waits in the output register so the next beat
// can be taken while the previous result is still pending. A second finished
// result holds the sequencer until the output register frees. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module sorted_session_time_table #(
    parameter int DEPTH = sstt_pkg::DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sstt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sstt_pkg::out_t m_data
);
    import sstt_pkg::*;

    logic out_free;
    logic res_valid;
    out_t res_data;
    logic m_valid_reg;
    out_t m_data_reg;

    // The output slot is free when empty or when its beat leaves this cycle.
    assign out_free = !m_valid_reg || m_ready;

    sstt_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_data  (s_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Hold the result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
